// ===== design/uhid_pkg.sv =====
// shared types, codes and constants of the usb hid control endpoint responder
package uhid_pkg;

  // string descriptors the design supports, and the length registers that back them
  localparam int MaxStrings = 4;
  localparam int NumStrLen  = 4;
  localparam int StrLimW    = 5;

  // configuration register indexes
  localparam int CfgIdxW = 4;
  localparam int CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] CfgDeviceLen = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgConfigLen = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgReportLen = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgStrCount  = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgStrLen0   = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgStrLen1   = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgStrLen2   = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgStrLen3   = 4'd7;

  // standard request codes and the class interface request type
  localparam logic [7:0] ReqGetDescriptor = 8'h06;
  localparam logic [7:0] ReqSetAddress    = 8'h05;
  localparam logic [7:0] ReqSetConfig     = 8'h09;
  localparam logic [7:0] ReqTypeClassIf   = 8'h21;

  // descriptor types
  localparam logic [7:0] DescDevice = 8'h01;
  localparam logic [7:0] DescConfig = 8'h02;
  localparam logic [7:0] DescString = 8'h03;
  localparam logic [7:0] DescReport = 8'h22;

  // ep0 actions
  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActData  = 2'd1;
  localparam logic [1:0] ActZlp   = 2'd2;
  localparam logic [1:0] ActStall = 2'd3;

  // descriptor kinds
  localparam logic [1:0] KindDevice = 2'd0;
  localparam logic [1:0] KindConfig = 2'd1;
  localparam logic [1:0] KindString = 2'd2;
  localparam logic [1:0] KindReport = 2'd3;

  // buffer completion bits
  localparam int BufEp0In  = 0;
  localparam int BufEp1In  = 2;
  localparam int BufEp1Out = 3;

  typedef struct packed {
    logic        bus_reset;
    logic        setup_seen;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] setup_value;
    logic [15:0] setup_length;
    logic [3:0]  buffers_done;
  } in_item_t;

  typedef struct packed {
    logic [1:0] ep0_action;
    logic [9:0] ep0_length;
    logic [1:0] descriptor_kind;
    logic [7:0] descriptor_index;
    logic       expect_status_out;
    logic       address_written;
    logic [6:0] device_address;
    logic       ep1_enable;
    logic       ep1_in_arm;
    logic       ep1_in_pid;
    logic       ep1_out_arm;
    logic       ep1_out_pid;
  } out_item_t;

  typedef struct packed {
    logic [7:0]                 device_desc_len;
    logic [9:0]                 config_desc_len;
    logic [9:0]                 report_desc_len;
    logic [2:0]                 string_count;
    logic [NumStrLen-1:0][7:0]  string_len;
  } cfg_t;

endpackage

// ===== design/uhid_cfg_regs.sv =====
// configuration register file of the responder
module uhid_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [uhid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uhid_pkg::CfgDataW-1:0] cfg_data_i,
  output uhid_pkg::cfg_t                cfg_o
);

  uhid_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        uhid_pkg::CfgDeviceLen: cfg_d.device_desc_len = cfg_data_i[7:0];
        uhid_pkg::CfgConfigLen: cfg_d.config_desc_len = cfg_data_i[9:0];
        uhid_pkg::CfgReportLen: cfg_d.report_desc_len = cfg_data_i[9:0];
        uhid_pkg::CfgStrCount:  cfg_d.string_count    = cfg_data_i[2:0];
        uhid_pkg::CfgStrLen0:   cfg_d.string_len[0]   = cfg_data_i[7:0];
        uhid_pkg::CfgStrLen1:   cfg_d.string_len[1]   = cfg_data_i[7:0];
        uhid_pkg::CfgStrLen2:   cfg_d.string_len[2]   = cfg_data_i[7:0];
        uhid_pkg::CfgStrLen3:   cfg_d.string_len[3]   = cfg_data_i[7:0];
        default: ; // writes beyond the list are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_desc_len <= 8'd18;
      cfg_q.config_desc_len <= 10'd34;
      cfg_q.report_desc_len <= '0;
      cfg_q.string_count    <= '0;
      cfg_q.string_len      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/uhid_core.sv =====
// request decode, address and ep1 toggle state of the responder
module uhid_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  uhid_pkg::in_item_t  item_i,
  input  uhid_pkg::cfg_t      cfg_i,
  output uhid_pkg::out_item_t result_o
);

  logic [6:0] pend_addr_q, pend_addr_d;
  logic [6:0] cur_addr_q, cur_addr_d;
  logic       in_tog_q, in_tog_d;
  logic       out_tog_q, out_tog_d;
  logic       ep_en_q, ep_en_d;

  always_comb begin
    uhid_pkg::out_item_t res;
    logic [7:0]  dtype;
    logic [7:0]  didx;
    logic [uhid_pkg::StrLimW-1:0] lim;
    logic        found;
    logic [9:0]  dlen;
    logic [1:0]  kind;

    res         = '0;
    pend_addr_d = pend_addr_q;
    cur_addr_d  = cur_addr_q;
    in_tog_d    = in_tog_q;
    out_tog_d   = out_tog_q;
    ep_en_d     = ep_en_q;
    dtype       = item_i.setup_value[15:8];
    didx        = item_i.setup_value[7:0];
    found       = 1'b0;
    dlen        = '0;
    kind        = uhid_pkg::KindDevice;

    // usable string count is the smallest of the register, the build limit and the table
    lim = {{(uhid_pkg::StrLimW-3){1'b0}}, cfg_i.string_count};
    if (lim > uhid_pkg::StrLimW'(uhid_pkg::MaxStrings)) begin
      lim = uhid_pkg::StrLimW'(uhid_pkg::MaxStrings);
    end
    if (lim > uhid_pkg::StrLimW'(uhid_pkg::NumStrLen)) begin
      lim = uhid_pkg::StrLimW'(uhid_pkg::NumStrLen);
    end

    if (item_i.bus_reset) begin
      cur_addr_d          = '0;
      pend_addr_d         = '0;
      res.address_written = 1'b1;
    end

    if (item_i.setup_seen) begin
      case (item_i.request_code)
        uhid_pkg::ReqGetDescriptor: begin
          case (dtype)
            uhid_pkg::DescDevice: begin
              found = 1'b1;
              dlen  = {2'b00, cfg_i.device_desc_len};
              kind  = uhid_pkg::KindDevice;
            end
            uhid_pkg::DescConfig: begin
              found = 1'b1;
              dlen  = cfg_i.config_desc_len;
              kind  = uhid_pkg::KindConfig;
            end
            uhid_pkg::DescString: begin
              if ({{(uhid_pkg::StrLimW > 8 ? 0 : 8-uhid_pkg::StrLimW){1'b0}}, lim} > didx) begin
                found = 1'b1;
                dlen  = {2'b00, cfg_i.string_len[didx[1:0]]};
                kind  = uhid_pkg::KindString;
                res.descriptor_index = didx;
              end
            end
            uhid_pkg::DescReport: begin
              found = 1'b1;
              dlen  = cfg_i.report_desc_len;
              kind  = uhid_pkg::KindReport;
            end
            default: found = 1'b0;
          endcase
          if (found) begin
            res.ep0_action        = uhid_pkg::ActData;
            res.descriptor_kind   = kind;
            res.expect_status_out = 1'b1;
            res.ep0_length = (item_i.setup_length < {6'd0, dlen}) ?
                             item_i.setup_length[9:0] : dlen;
          end else begin
            res.ep0_action       = uhid_pkg::ActStall;
            res.descriptor_index = '0;
          end
        end
        uhid_pkg::ReqSetAddress: begin
          pend_addr_d    = item_i.setup_value[6:0];
          res.ep0_action = uhid_pkg::ActZlp;
        end
        uhid_pkg::ReqSetConfig: begin
          // first report goes out as data0, both toggles restart
          ep_en_d         = 1'b1;
          res.ep1_in_arm  = 1'b1;
          res.ep1_in_pid  = 1'b0;
          in_tog_d        = 1'b1;
          res.ep1_out_arm = 1'b1;
          res.ep1_out_pid = 1'b0;
          out_tog_d       = 1'b0;
          res.ep0_action  = uhid_pkg::ActZlp;
        end
        default: begin
          if (item_i.request_type == uhid_pkg::ReqTypeClassIf) begin
            res.ep0_action = uhid_pkg::ActZlp;
          end else begin
            res.ep0_action = uhid_pkg::ActStall;
          end
        end
      endcase
    end

    // status stage of set address done, apply the pending address
    if (item_i.buffers_done[uhid_pkg::BufEp0In] && (pend_addr_d != '0)) begin
      cur_addr_d          = pend_addr_d;
      pend_addr_d         = '0;
      res.address_written = 1'b1;
    end
    if (item_i.buffers_done[uhid_pkg::BufEp1In]) begin
      res.ep1_in_arm = 1'b1;
      res.ep1_in_pid = in_tog_d;
      in_tog_d       = ~in_tog_d;
    end
    if (item_i.buffers_done[uhid_pkg::BufEp1Out]) begin
      out_tog_d       = ~out_tog_d;
      res.ep1_out_arm = 1'b1;
      res.ep1_out_pid = out_tog_d;
    end

    res.device_address = cur_addr_d;
    res.ep1_enable     = ep_en_d;
    result_o           = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_addr_q <= '0;
      cur_addr_q  <= '0;
      in_tog_q    <= 1'b0;
      out_tog_q   <= 1'b0;
      ep_en_q     <= 1'b0;
    end else if (step_i) begin
      pend_addr_q <= pend_addr_d;
      cur_addr_q  <= cur_addr_d;
      in_tog_q    <= in_tog_d;
      out_tog_q   <= out_tog_d;
      ep_en_q     <= ep_en_d;
    end
  end

endmodule

// ===== design/usb_hid_control_endpoint_responder_top.sv =====
// top level of the usb hid control endpoint responder
// Each accepted controller event is held in an input register, decoded combinationally against the
// endpoint state and the descriptor length registers, and its response lands in a result
// register; one item can be taken every cycle while the result register is not stalled, and the
// only stall comes from the result register when out_ready_i is low.
// The configuration port is always ready and should be written only while no item is in flight.
module usb_hid_control_endpoint_responder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  uhid_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output uhid_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [uhid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uhid_pkg::CfgDataW-1:0] cfg_data_i
);

  logic                in_valid_q;
  uhid_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  uhid_pkg::out_item_t out_item_q;
  uhid_pkg::out_item_t result;
  uhid_pkg::cfg_t      cfg;
  logic                step;

  // item moves from the input register to the result register
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign cfg_ready_o = 1'b1;

  uhid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  uhid_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
